### rtl/gcd_pkg.sv
package gcd_pkg;

    localparam int CORDIC_STAGES_DEF = 24;
    localparam int ROT_W = 34;
    localparam int VEC_W = 37;
    localparam int CORDIC_K = 652032874;

    typedef logic [31:0] t_angle;

    localparam t_angle QUARTER_TURN = 32'h4000_0000;
    localparam t_angle HALF_TURN = 32'h8000_0000;
    localparam t_angle THREE_QUARTER_TURN = 32'hC000_0000;

    localparam logic [31:0] BANG_RECIP = 32'd2562047788;
    localparam logic [29:0] BANG_DIV = 30'd900000000;
    localparam logic [32:0] BANG_DIV2 = 33'd1800000000;
    localparam logic [28:0] BANG_HALF = 29'd450000000;

    localparam logic [25:0] METERS_PER_TURN = 26'd40041452;
    localparam logic [15:0] CENTIDEG_PER_TURN = 16'd36000;

    localparam logic REG_HOME_LAT = 1'b0;
    localparam logic REG_HOME_LON = 1'b1;

    function automatic t_angle atan_tab(input logic [4:0] i);
        t_angle v;
        case (i)
            5'd0: v = 32'd536870912;
            5'd1: v = 32'd316933406;
            5'd2: v = 32'd167458907;
            5'd3: v = 32'd85004756;
            5'd4: v = 32'd42667331;
            5'd5: v = 32'd21354465;
            5'd6: v = 32'd10679838;
            5'd7: v = 32'd5340245;
            5'd8: v = 32'd2670163;
            5'd9: v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

### rtl/gcd_rot.sv
module gcd_rot #(
    parameter int STAGES = gcd_pkg::CORDIC_STAGES_DEF
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  gcd_pkg::t_angle     i_angle,
    output logic signed [31:0]  o_cos,
    output logic signed [31:0]  o_sin
);
    import gcd_pkg::*;

    logic signed [ROT_W-1:0] r_x [0:STAGES];
    logic signed [ROT_W-1:0] r_y [0:STAGES];
    logic signed [ROT_W-1:0] r_z [0:STAGES];
    logic                    r_flip [0:STAGES];

    logic   flip;
    t_angle ang;

    // fold the left half plane onto the right one
    assign flip = (i_angle - QUARTER_TURN) < HALF_TURN;
    assign ang = flip ? i_angle + HALF_TURN : i_angle;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= ROT_W'(CORDIC_K);
            r_y[0] <= '0;
            r_z[0] <= ROT_W'($signed(ang));
            r_flip[0] <= flip;
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        localparam logic signed [ROT_W-1:0] ATN = ROT_W'(atan_tab(5'(i)));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[i][ROT_W-1]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - ATN;
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + ATN;
                end
                r_flip[i+1] <= r_flip[i];
            end
        end
    end

    assign o_cos = 32'(r_flip[STAGES] ? -r_x[STAGES] : r_x[STAGES]);
    assign o_sin = 32'(r_flip[STAGES] ? -r_y[STAGES] : r_y[STAGES]);

endmodule

### rtl/gcd_vec.sv
module gcd_vec #(
    parameter int STAGES = gcd_pkg::CORDIC_STAGES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [gcd_pkg::VEC_W-1:0] i_x,
    input  logic signed [gcd_pkg::VEC_W-1:0] i_y,
    output logic signed [gcd_pkg::VEC_W-1:0] o_mag,
    output gcd_pkg::t_angle               o_ang
);
    import gcd_pkg::*;

    logic signed [VEC_W-1:0] r_x [0:STAGES];
    logic signed [VEC_W-1:0] r_y [0:STAGES];
    t_angle                  r_z [0:STAGES];

    logic neg;

    assign neg = i_x[VEC_W-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= neg ? -i_x : i_x;
            r_y[0] <= neg ? -i_y : i_y;
            r_z[0] <= neg ? HALF_TURN : '0;
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        localparam t_angle ATN = atan_tab(5'(i));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_y[i][VEC_W-1]) begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + ATN;
                end else begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - ATN;
                end
            end
        end
    end

    assign o_mag = r_x[STAGES];
    assign o_ang = r_z[STAGES];

endmodule

### rtl/great_circle_distance_and_course.sv
// Great-circle distance and initial course from a vehicle position to a home point.
// Input stream: one word per position, output stream: one word per result, in order.
// Home latitude and longitude are written through the register port; the user writes
// them only while idle, which the block does not enforce; both reset to zero.
// The datapath is fully pipelined: while the output is not stalled, one position is
// taken every cycle and one result leaves every cycle. Data passes through three CORDIC
// chains in series (rotation, vectoring for the chord, vectoring for the angle)
// plus the degree-to-binary-angle conversion and the multiply stages.
// A one-word skid stage sits behind the output register, so the block keeps taking
// input while a result waits; when both hold a word the whole pipeline freezes and
// s_tready falls. Nothing is dropped or repeated.
// Reset clears all valid bits and the home registers.
module great_circle_distance_and_course #(
    parameter int CORDIC_STAGES = gcd_pkg::CORDIC_STAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // uav_latitude[30:0], uav_longitude[62:31]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // distance_m[24:0], course_centideg[40:25]
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import gcd_pkg::*;

    localparam int S = CORDIC_STAGES;
    localparam int LAT = 3 * S + 12;

    function automatic logic signed [34:0] mul30(input logic signed [32:0] a,
                                                 input logic signed [32:0] b);
        logic signed [65:0] p;
        p = a * b;
        return p[64:30];
    endfunction

    logic en;
    logic [LAT-1:0] r_vld;

    logic [30:0] r_home_lat;
    logic [31:0] r_home_lon;

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_home_lat <= '0;
            r_home_lon <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_HOME_LAT: r_home_lat <= i_cfg_data[30:0];
                REG_HOME_LON: r_home_lon <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_s_tvalid};
        end
    end

    // degrees to binary angle: 0 home lat, 1 uav lat, 2 home lon, 3 uav lon
    logic signed [31:0] r_in [0:3];
    logic        r_bs [0:3];
    logic [31:0] r_bn [0:3];
    logic [63:0] r_bp [0:3];
    logic        r_bs2 [0:3];
    logic [31:0] r_bn2 [0:3];
    logic [31:0] r_b0 [0:3];
    logic [32:0] r_bm [0:3];
    t_angle      r_bang [0:3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in[0] <= {r_home_lat[30], r_home_lat};
            r_in[1] <= {i_s_tdata[30], i_s_tdata[30:0]};
            r_in[2] <= r_home_lon;
            r_in[3] <= i_s_tdata[62:31];
        end
    end

    for (genvar k = 0; k < 4; k++) begin : g_bang
        logic [31:0] mag;
        logic [31:0] r0;
        logic [61:0] r0m;
        logic [32:0] rem;
        logic [31:0] q;
        assign mag = r_in[k][31] ? 32'(-r_in[k]) : 32'(r_in[k]);
        assign r0 = r_bp[k][62:31];
        assign r0m = r0 * BANG_DIV;
        assign rem = {r_bn2[k][2:0], 30'd0} + 33'(BANG_HALF) - r_bm[k];
        assign q = r_b0[k] + 32'(rem >= 33'(BANG_DIV)) + 32'(rem >= BANG_DIV2);
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_bs[k] <= r_in[k][31];
                r_bn[k] <= mag;
                r_bp[k] <= 64'(mag) * 64'(BANG_RECIP);
                r_bs2[k] <= r_bs[k];
                r_bn2[k] <= r_bn[k];
                r_b0[k] <= r0;
                r_bm[k] <= r0m[32:0];
                r_bang[k] <= r_bs2[k] ? -q : q;
            end
        end
    end

    // sines and cosines
    logic signed [31:0] ch, sh, cu, su, cd, sd;

    gcd_rot #(.STAGES(S)) u_rot_home (
        .i_clk(i_clk), .i_en(en), .i_angle(r_bang[0]), .o_cos(ch), .o_sin(sh));
    gcd_rot #(.STAGES(S)) u_rot_uav (
        .i_clk(i_clk), .i_en(en), .i_angle(r_bang[1]), .o_cos(cu), .o_sin(su));
    gcd_rot #(.STAGES(S)) u_rot_dlon (
        .i_clk(i_clk), .i_en(en), .i_angle(r_bang[2] - r_bang[3]), .o_cos(cd), .o_sin(sd));

    logic signed [32:0] r_chsu, r_shcu, r_cusd, r_shsu, r_chcu, r_sdch, r_cush, r_such;
    logic signed [31:0] r_cd;
    logic signed [34:0] r_a, r_b, r_den, r_ca, r_cb;
    logic               r_czero;
    logic signed [34:0] n_ca, n_cb;

    assign n_ca = 35'(r_sdch);
    assign n_cb = 35'(r_cush) - mul30(r_such, 33'(r_cd));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_chsu <= 33'(mul30(33'(ch), 33'(su)));
            r_shcu <= 33'(mul30(33'(sh), 33'(cu)));
            r_cusd <= 33'(mul30(33'(cu), 33'(sd)));
            r_shsu <= 33'(mul30(33'(sh), 33'(su)));
            r_chcu <= 33'(mul30(33'(ch), 33'(cu)));
            r_sdch <= 33'(mul30(33'(sd), 33'(ch)));
            r_cush <= 33'(mul30(33'(cu), 33'(sh)));
            r_such <= 33'(mul30(33'(su), 33'(ch)));
            r_cd <= cd;
            r_a <= 35'(r_chsu) - mul30(r_shcu, 33'(r_cd));
            r_b <= 35'(r_cusd);
            r_den <= 35'(r_shsu) + mul30(r_chcu, 33'(r_cd));
            r_ca <= n_ca;
            r_cb <= n_cb;
            r_czero <= (n_ca == '0) && (n_cb == '0);
        end
    end

    // chord length and course angle
    logic signed [VEC_W-1:0] mag1, mag2, mag3;
    t_angle ang1, ang2, ang3;

    gcd_vec #(.STAGES(S)) u_vec_chord (
        .i_clk(i_clk), .i_en(en), .i_x(VEC_W'(r_a)), .i_y(VEC_W'(r_b)),
        .o_mag(mag1), .o_ang(ang1));
    gcd_vec #(.STAGES(S)) u_vec_course (
        .i_clk(i_clk), .i_en(en), .i_x(VEC_W'(r_cb)), .i_y(VEC_W'(r_ca)),
        .o_mag(mag3), .o_ang(ang3));

    logic signed [34:0] r_den_d [0:S];
    t_angle             r_cang_d [0:S+1];
    logic               r_cz_d [0:2*S+2];
    logic signed [34:0] r_magk, r_den3;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_den_d[0] <= r_den;
            for (int j = 1; j <= S; j++) r_den_d[j] <= r_den_d[j-1];
            r_cang_d[0] <= ang3;
            for (int j = 1; j <= S + 1; j++) r_cang_d[j] <= r_cang_d[j-1];
            r_cz_d[0] <= r_czero;
            for (int j = 1; j <= 2 * S + 2; j++) r_cz_d[j] <= r_cz_d[j-1];
            r_magk <= mul30(33'(mag1), 33'(CORDIC_K));
            r_den3 <= r_den_d[S];
        end
    end

    gcd_vec #(.STAGES(S)) u_vec_central (
        .i_clk(i_clk), .i_en(en), .i_x(VEC_W'(r_den3)), .i_y(VEC_W'(r_magk)),
        .o_mag(mag2), .o_ang(ang2));

    // scale to meters and centidegrees
    t_angle      ang_cl;
    logic [57:0] r_pd;
    logic [47:0] r_pc;
    logic        r_cz;
    logic [57:0] dsum;
    logic [47:0] csum;
    logic [24:0] r_dist;
    logic [15:0] r_crs;

    assign ang_cl = (ang2 > THREE_QUARTER_TURN) ? '0 :
                    (ang2 > HALF_TURN) ? HALF_TURN : ang2;
    assign dsum = r_pd + 58'(HALF_TURN);
    assign csum = r_pc + 48'(HALF_TURN);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pd <= 58'(ang_cl) * 58'(METERS_PER_TURN);
            r_pc <= 48'(r_cang_d[S+1]) * 48'(CENTIDEG_PER_TURN);
            r_cz <= r_cz_d[2*S+2];
            r_dist <= dsum[56:32];
            r_crs <= (r_cz || csum[47:32] >= CENTIDEG_PER_TURN) ? '0 : csum[47:32];
        end
    end

    // output register and skid
    logic        r_skid_vld;
    logic [47:0] r_skid;
    logic [47:0] pipe_word;
    logic        out_free;

    assign pipe_word = {7'd0, r_crs, r_dist};
    assign out_free = !o_m_tvalid || i_m_tready;
    assign en = !r_skid_vld;
    assign o_s_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_m_tvalid <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (out_free) begin
                o_m_tvalid <= 1'b1;
                r_skid_vld <= 1'b0;
            end
        end else if (out_free) begin
            o_m_tvalid <= r_vld[LAT-1];
        end else begin
            r_skid_vld <= r_vld[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (out_free) o_m_tdata <= r_skid;
        end else if (out_free) begin
            o_m_tdata <= pipe_word;
        end else begin
            r_skid <= pipe_word;
        end
    end

endmodule

### rtl/gcd_check.sv
module gcd_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [47:0] o_m_tdata
);
    import gcd_pkg::*;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("output word changed while stalled");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[40:25] < CENTIDEG_PER_TURN
                    && o_m_tdata[24:0] <= 25'd20020726 && o_m_tdata[47:41] == '0)
        else $error("result word out of range");

endmodule

bind great_circle_distance_and_course gcd_check u_check (.*);

### sim/great_circle_distance_and_course_tb.sv
`timescale 1ns / 1ps

module great_circle_distance_and_course_tb;
    import gcd_pkg::*;

    localparam int STAGES = CORDIC_STAGES_DEF;
    localparam int RANDOM_ITEMS = 800;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 3 * STAGES + 40;
    localparam int HOLD_CYCLES = 400;

    localparam longint ARC_STEP [32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1, 1, 0
    };

    typedef struct {
        logic [24:0] meters;
        logic [15:0] crs;
    } t_fix;

    typedef struct {
        longint lat;
        longint lon;
    } t_pos;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [31:0] cfg_data;

    t_fix   fix_queue[$];
    longint home_lat;
    longint home_lon;
    int     tx_idle_pct;
    int     rx_idle_pct;
    int     hold_cnt;
    bit     hold_start;
    int     stall_cycles;
    int     errors;

    great_circle_distance_and_course DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint mul_q30(input longint a, input longint b);
        return (a * b) >>> 30;
    endfunction

    function automatic t_angle deg_to_angle(input longint d);
        longint q;
        longint r;
        q = d * 64'sd1073741824;
        if (q >= 0) begin
            r = (q + 64'sd450000000) / 64'sd900000000;
        end else begin
            r = -((-q + 64'sd450000000) / 64'sd900000000);
        end
        return t_angle'(r[31:0]);
    endfunction

    function automatic void sin_cos(input t_angle ang, output longint c, output longint s);
        bit     flip;
        t_angle a;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        a = ang;
        flip = t_angle'(a - QUARTER_TURN) < HALF_TURN;
        if (flip) begin
            a = a + HALF_TURN;
        end
        x = CORDIC_K;
        y = 0;
        z = (a < HALF_TURN) ? longint'(a) : longint'(a) - 64'sd4294967296;
        for (int i = 0; i < STAGES && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ARC_STEP[i];
            end else begin
                x += dx; y -= dy; z += ARC_STEP[i];
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        c = x;
        s = y;
    endfunction

    function automatic t_angle arc_of(input longint xi, input longint yi, output longint mag);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = xi;
        y = yi;
        z = 0;
        if (x < 0) begin
            x = -x; y = -y; z = 64'sd2147483648;
        end
        for (int i = 0; i < STAGES && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += ARC_STEP[i];
            end else begin
                x -= dx; y += dy; z -= ARC_STEP[i];
            end
        end
        mag = x;
        return t_angle'(z[31:0]);
    endfunction

    function automatic t_fix predict_fix(input longint lat, input longint lon);
        t_fix   f;
        t_angle hla;
        t_angle hlo;
        t_angle ula;
        t_angle ulo;
        t_angle ang;
        longint ch, sh, cu, su, cd, sd, a, b, den, mag, spare, prod;
        hla = deg_to_angle(home_lat);
        hlo = deg_to_angle(home_lon);
        ula = deg_to_angle(lat);
        ulo = deg_to_angle(lon);
        sin_cos(hla, ch, sh);
        sin_cos(ula, cu, su);
        sin_cos(t_angle'(hlo - ulo), cd, sd);
        a = mul_q30(ch, su) - mul_q30(mul_q30(sh, cu), cd);
        b = mul_q30(cu, sd);
        den = mul_q30(sh, su) + mul_q30(mul_q30(ch, cu), cd);
        ang = arc_of(a, b, mag);
        mag = mul_q30(mag, CORDIC_K);
        ang = arc_of(den, mag, spare);
        if (ang > THREE_QUARTER_TURN) begin
            ang = '0;
        end else if (ang > HALF_TURN) begin
            ang = HALF_TURN;
        end
        prod = (longint'(ang) * longint'(METERS_PER_TURN) + 64'sd2147483648) >>> 32;
        f.meters = prod[24:0];
        a = mul_q30(sd, ch);
        b = mul_q30(cu, sh) - mul_q30(mul_q30(su, ch), cd);
        if (a == 0 && b == 0) begin
            f.crs = '0;
        end else begin
            ang = arc_of(b, a, spare);
            prod = (longint'(ang) * longint'(CENTIDEG_PER_TURN) + 64'sd2147483648) >>> 32;
            f.crs = (prod >= longint'(CENTIDEG_PER_TURN)) ? 16'd0 : prod[15:0];
        end
        return f;
    endfunction

    task automatic write_home(input logic idx, input longint value);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data = value[31:0];
        @(negedge clk);
        cfg_wr_en = 1'b0;
        if (idx == REG_HOME_LAT) begin
            home_lat = longint'(signed'(value[30:0]));
        end else begin
            home_lon = longint'(signed'(value[31:0]));
        end
    endtask

    task automatic send_pos(input longint lat, input longint lon);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = {1'b0, lon[31:0], lat[30:0]};
        do @(posedge clk); while (!s_tready);
        fix_queue.push_back(predict_fix(longint'(signed'(lat[30:0])),
                                        longint'(signed'(lon[31:0]))));
        @(negedge clk);
    endtask

    task automatic drain;
        s_tvalid = 1'b0;
        while (fix_queue.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic t_pos random_pos;
        t_pos p;
        if ($urandom_range(99) < 80) begin
            p.lat = longint'($urandom_range(32'd1800000000)) - 64'sd900000000;
            p.lon = longint'($urandom_range(32'd3600000000)) - 64'sd1800000000;
        end else begin
            p.lat = longint'(signed'($urandom() & 32'h7FFF_FFFF) <<< 1) >>> 1;
            p.lon = longint'(signed'($urandom()));
        end
        return p;
    endfunction

    always @(negedge clk) begin
        if (hold_start) begin
            hold_cnt = HOLD_CYCLES;
            hold_start = 1'b0;
        end
        if (hold_cnt > 0) begin
            m_tready = 1'b0;
            hold_cnt--;
        end else begin
            m_tready = $urandom_range(99) >= rx_idle_pct;
        end
    end

    always @(posedge clk) begin
        t_fix f;
        if (rst_n && m_tvalid && m_tready) begin
            if (fix_queue.size() == 0) begin
                $display("%0t unexpected word expected none actual %h", $time, m_tdata);
                errors++;
            end else begin
                f = fix_queue.pop_front();
                if (m_tdata[24:0] !== f.meters) begin
                    $display("%0t distance expected %0d actual %0d", $time, f.meters,
                             m_tdata[24:0]);
                    errors++;
                end
                if (m_tdata[40:25] !== f.crs) begin
                    $display("%0t course expected %0d actual %0d", $time, f.crs,
                             m_tdata[40:25]);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        t_pos   pos;
        t_pos   directed [20];
        longint homes [6][2];
        int     sent;
        directed = '{
            '{0, 0}, '{900000000, 0}, '{-900000000, 0}, '{0, 1800000000},
            '{0, -1800000000}, '{900000000, 1800000000}, '{-900000000, -1800000000},
            '{1073741823, 2147483647}, '{-1073741824, -2147483648}, '{1, 0},
            '{0, 1}, '{-1, -1}, '{0, 900000000}, '{450000000, -450000000},
            '{899999999, 1234567}, '{-899999999, -1799999999}, '{1000000000, 0},
            '{-1000000000, 3}, '{0, 1799999999}, '{123456789, -987654321}
        };
        homes = '{
            '{0, 0}, '{900000000, 1800000000}, '{-900000000, -1800000000},
            '{473977000, 85449000}, '{-338688000, 1512093000}, '{0, 0}
        };
        errors = 0;
        stall_cycles = 0;
        hold_cnt = 0;
        hold_start = 1'b0;
        home_lat = 0;
        home_lon = 0;
        tx_idle_pct = 34;
        rx_idle_pct = 50;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_HOME_LAT;
        cfg_data = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        sent = 0;
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 5) begin
                pos = random_pos();
                homes[ph][0] = pos.lat;
                homes[ph][1] = pos.lon;
            end
            if (ph > 0) begin
                drain();
                write_home(REG_HOME_LAT, homes[ph][0]);
                write_home(REG_HOME_LON, homes[ph][1]);
            end
            for (int k = 0; k < 20; k++) begin
                if (ph == 0 || k < 6) begin
                    send_pos(directed[k].lat, directed[k].lon);
                end
            end
            send_pos(home_lat, home_lon);
            send_pos(home_lat, home_lon + 1);
            send_pos(-home_lat, home_lon + 64'sd1800000000);
            if (ph == 1) begin
                hold_start = 1'b1;
            end
            for (int k = 0; k < RANDOM_ITEMS / 6; k++) begin
                if (sent < RANDOM_ITEMS / 3) begin
                    tx_idle_pct = 34; rx_idle_pct = 50;
                end else if (sent < 2 * RANDOM_ITEMS / 3) begin
                    tx_idle_pct = 50; rx_idle_pct = 34;
                end else begin
                    tx_idle_pct = 0; rx_idle_pct = 0;
                end
                pos = random_pos();
                send_pos(pos.lat, pos.lon);
                sent++;
            end
        end
        drain();
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
